// File: sv/trinj_pkg.sv
package trinj_pkg;

  localparam int SlotCount = 5;
  localparam int SlotWidth = 40;
  localparam int ConfBit   = 0;
  localparam int TipBit    = 1;
  localparam int IdLsb     = 2;
  localparam int IdMsb     = 4;

  typedef logic [SlotWidth-1:0] slot_t;
  typedef logic [2:0]           slot_idx_t;
  typedef logic [7:0]           byte_t;

  localparam byte_t     ReportMatchReset = 8'd3;
  localparam slot_t     TipMask          = slot_t'(1) << TipBit;
  localparam slot_idx_t SlotLimit        = slot_idx_t'(SlotCount);

  typedef struct packed {
    byte_t       rpt_id;
    slot_t       contact_0;
    slot_t       contact_1;
    slot_t       contact_2;
    slot_t       contact_3;
    slot_t       contact_4;
    logic [15:0] scan_stamp;
    byte_t       num_contacts;
    byte_t       button;
    byte_t       reserved_byte;
  } report_t;

  typedef struct packed {
    byte_t       out_rpt_id;
    slot_t       out_contact_0;
    slot_t       out_contact_1;
    slot_t       out_contact_2;
    slot_t       out_contact_3;
    slot_t       out_contact_4;
    logic [15:0] out_scan_stamp;
    byte_t       out_num_contacts;
    byte_t       out_button;
    byte_t       out_reserved_byte;
  } result_t;

endpackage

// File: sv/trinj_repair.sv
module trinj_repair (
  input  trinj_pkg::report_t report,
  input  trinj_pkg::byte_t   match_id,
  input  trinj_pkg::slot_t   last_contacts [trinj_pkg::SlotCount],
  input  trinj_pkg::byte_t   last_count,
  output trinj_pkg::result_t result,
  output logic               store
);

  trinj_pkg::slot_t     cur      [trinj_pkg::SlotCount];
  trinj_pkg::slot_t     fixed    [trinj_pkg::SlotCount];
  trinj_pkg::slot_t     slots    [trinj_pkg::SlotCount];
  trinj_pkg::slot_idx_t src      [trinj_pkg::SlotCount];
  logic [trinj_pkg::SlotCount-1:0] active;
  logic [trinj_pkg::SlotCount-1:0] present;
  logic [trinj_pkg::SlotCount-1:0] missing;
  logic [2:0]           n_rel;
  trinj_pkg::slot_idx_t cc;
  trinj_pkg::byte_t     expected;
  trinj_pkg::byte_t     count;
  logic                 id_match;
  logic                 fix;

  assign cur[0] = report.contact_0;
  assign cur[1] = report.contact_1;
  assign cur[2] = report.contact_2;
  assign cur[3] = report.contact_3;
  assign cur[4] = report.contact_4;

  assign id_match = (report.rpt_id == match_id);

  // Scan the stored report for touching and released contacts
  always_comb begin
    trinj_pkg::slot_idx_t id;
    active = '0;
    n_rel  = '0;
    for (int i = 0; i < trinj_pkg::SlotCount; i++) begin
      src[i] = '0;
    end
    for (int i = 0; i < trinj_pkg::SlotCount; i++) begin
      id = last_contacts[i][trinj_pkg::IdMsb:trinj_pkg::IdLsb];
      if (last_contacts[i][trinj_pkg::ConfBit] && (id < trinj_pkg::SlotLimit)) begin
        if (last_contacts[i][trinj_pkg::TipBit]) begin
          active[id] = 1'b1;
          src[id]    = trinj_pkg::slot_idx_t'(i);
        end else begin
          n_rel = n_rel + 3'd1;
        end
      end
    end
  end

  always_comb begin
    trinj_pkg::slot_idx_t id;
    present = '0;
    for (int i = 0; i < trinj_pkg::SlotCount; i++) begin
      id = cur[i][trinj_pkg::IdMsb:trinj_pkg::IdLsb];
      if (cur[i][trinj_pkg::ConfBit] && (id < trinj_pkg::SlotLimit)) begin
        present[id] = 1'b1;
      end
    end
  end

  assign missing  = active & ~present;
  assign expected = last_count - trinj_pkg::byte_t'(n_rel);

  // Append missing contacts as releases after the reported ones
  always_comb begin
    fixed = cur;
    cc    = report.num_contacts[2:0];
    if (report.num_contacts < trinj_pkg::byte_t'(trinj_pkg::SlotCount)) begin
      for (int i = 0; i < trinj_pkg::SlotCount; i++) begin
        if (missing[i] && (cc < trinj_pkg::SlotLimit)) begin
          fixed[cc] = last_contacts[src[i]] & ~trinj_pkg::TipMask;
          cc        = cc + 3'd1;
        end
      end
    end
  end

  assign fix = id_match && (report.num_contacts < last_count)
               && (expected != report.num_contacts);

  always_comb begin
    slots = cur;
    count = report.num_contacts;
    if (fix) begin
      slots = fixed;
      if (report.num_contacts < trinj_pkg::byte_t'(trinj_pkg::SlotCount)) begin
        count = trinj_pkg::byte_t'(cc);
      end
    end
  end

  assign store = id_match;

  assign result.out_rpt_id        = report.rpt_id;
  assign result.out_contact_0     = slots[0];
  assign result.out_contact_1     = slots[1];
  assign result.out_contact_2     = slots[2];
  assign result.out_contact_3     = slots[3];
  assign result.out_contact_4     = slots[4];
  assign result.out_scan_stamp    = report.scan_stamp;
  assign result.out_num_contacts  = count;
  assign result.out_button        = report.button;
  assign result.out_reserved_byte = report.reserved_byte;

endmodule

// File: sv/touch_release_injector_top.sv
// channel  | direction | handshake            | payload
// report   | in        | report_valid / stall | report (trinj_pkg::report_t)
// result   | out       | result_valid / stall | result (trinj_pkg::result_t)
// cfg      | in        | cfg_valid / ready    | cfg_data (report id to repair)
//
// One report per cycle while report_stall is low; a report goes through the
// input register, then repair logic into the result register (held on stall).
// Synchronous reset clears both stages, the stored report and sets the id to 3.
// The input register keeps taking reports while a result waits; report_stall
// rises only when both stages are full and result is stalled.
module touch_release_injector_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                report_valid,
  output logic                report_stall,
  input  trinj_pkg::report_t  report,
  output logic                result_valid,
  input  logic                result_stall,
  output trinj_pkg::result_t  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  trinj_pkg::byte_t    cfg_data
);

  logic               hold_valid;
  trinj_pkg::report_t hold;
  trinj_pkg::byte_t   match_id;
  trinj_pkg::slot_t   last_contacts [trinj_pkg::SlotCount];
  trinj_pkg::byte_t   last_count;
  trinj_pkg::result_t result_next;
  logic               store;
  logic               advance;
  logic               accept;

  trinj_repair u_repair (
    .report        (hold),
    .match_id      (match_id),
    .last_contacts (last_contacts),
    .last_count    (last_count),
    .result        (result_next),
    .store         (store)
  );

  assign advance      = hold_valid && (!result_valid || !result_stall);
  assign report_stall = hold_valid && !advance;
  assign accept       = report_valid && !report_stall;
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      match_id     <= trinj_pkg::ReportMatchReset;
      last_count   <= '0;
      for (int i = 0; i < trinj_pkg::SlotCount; i++) begin
        last_contacts[i] <= '0;
      end
    end else begin
      hold_valid <= accept || (hold_valid && !advance);
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        match_id <= cfg_data;
      end
      // Update the stored report on each transfer of a report with the matching id
      if (advance && store) begin
        last_contacts[0] <= result_next.out_contact_0;
        last_contacts[1] <= result_next.out_contact_1;
        last_contacts[2] <= result_next.out_contact_2;
        last_contacts[3] <= result_next.out_contact_3;
        last_contacts[4] <= result_next.out_contact_4;
        last_count       <= result_next.out_num_contacts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= report;
    end
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

// File: verif/touch_release_injector_top_test.sv
module touch_release_injector_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  class release_scoreboard;
    trinj_pkg::byte_t   match;
    trinj_pkg::slot_t   stored [trinj_pkg::SlotCount];
    trinj_pkg::byte_t   stored_count;
    trinj_pkg::result_t expected_q [$];
    int                 errors;
    int                 shown;

    function new();
      match = trinj_pkg::ReportMatchReset;
      foreach (stored[i]) stored[i] = '0;
      stored_count = '0;
      errors = 0;
      shown = 0;
    endfunction

    function void set_match(trinj_pkg::byte_t v);
      match = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_report(trinj_pkg::report_t r);
      trinj_pkg::result_t e;
      trinj_pkg::slot_t   s [trinj_pkg::SlotCount];
      trinj_pkg::byte_t   cnt;
      trinj_pkg::byte_t   want;
      logic [4:0]         touching;
      int                 src [trinj_pkg::SlotCount];
      int                 cc;
      logic [2:0]         id;
      s[0] = r.contact_0;
      s[1] = r.contact_1;
      s[2] = r.contact_2;
      s[3] = r.contact_3;
      s[4] = r.contact_4;
      cnt = r.num_contacts;
      e.out_rpt_id = r.rpt_id;
      e.out_scan_stamp = r.scan_stamp;
      e.out_button = r.button;
      e.out_reserved_byte = r.reserved_byte;
      if (r.rpt_id == match) begin
        if (cnt < stored_count) begin
          want = stored_count;
          touching = '0;
          foreach (src[i]) src[i] = 0;
          for (int i = 0; i < trinj_pkg::SlotCount; i++) begin
            id = stored[i][trinj_pkg::IdMsb:trinj_pkg::IdLsb];
            if (stored[i][trinj_pkg::ConfBit] && id < trinj_pkg::SlotCount) begin
              if (stored[i][trinj_pkg::TipBit]) begin
                src[id] = i;
                touching[id] = 1'b1;
              end else begin
                want = want - 8'd1;
              end
            end
          end
          if (want != cnt) begin
            for (int i = 0; i < trinj_pkg::SlotCount; i++) begin
              id = s[i][trinj_pkg::IdMsb:trinj_pkg::IdLsb];
              if (s[i][trinj_pkg::ConfBit] && id < trinj_pkg::SlotCount) touching[id] = 1'b0;
            end
            cc = cnt;
            for (int i = 0; i < trinj_pkg::SlotCount; i++) begin
              if (touching[i] && cc < trinj_pkg::SlotCount) begin
                s[cc] = stored[src[i]] & ~trinj_pkg::TipMask;
                cc++;
              end
            end
            cnt = trinj_pkg::byte_t'(cc);
          end
        end
        stored = s;
        stored_count = cnt;
      end
      e.out_contact_0 = s[0];
      e.out_contact_1 = s[1];
      e.out_contact_2 = s[2];
      e.out_contact_3 = s[3];
      e.out_contact_4 = s[4];
      e.out_num_contacts = cnt;
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (shown < 10) $display("mismatch %s: expected %h, got %h", name, want, got);
        shown++;
      end
    endfunction

    function void check_result(trinj_pkg::result_t got);
      trinj_pkg::result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (shown < 10) $display("unexpected result transfer: %h", got);
        shown++;
      end else begin
        want = expected_q.pop_front();
        compare_field("rpt_id", 64'(want.out_rpt_id), 64'(got.out_rpt_id));
        compare_field("contact_0", 64'(want.out_contact_0), 64'(got.out_contact_0));
        compare_field("contact_1", 64'(want.out_contact_1), 64'(got.out_contact_1));
        compare_field("contact_2", 64'(want.out_contact_2), 64'(got.out_contact_2));
        compare_field("contact_3", 64'(want.out_contact_3), 64'(got.out_contact_3));
        compare_field("contact_4", 64'(want.out_contact_4), 64'(got.out_contact_4));
        compare_field("scan_stamp", 64'(want.out_scan_stamp), 64'(got.out_scan_stamp));
        compare_field("num_contacts", 64'(want.out_num_contacts),
                      64'(got.out_num_contacts));
        compare_field("button", 64'(want.out_button), 64'(got.out_button));
        compare_field("reserved_byte", 64'(want.out_reserved_byte),
                      64'(got.out_reserved_byte));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               report_valid = 1'b0;
  logic               report_stall;
  trinj_pkg::report_t report = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  trinj_pkg::result_t result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  trinj_pkg::byte_t   cfg_data = '0;

  int send_idle = 34;
  int recv_idle = 59;

  release_scoreboard sb;

  touch_release_injector_top dut (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (report_valid && !report_stall) sb.note_report(report);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  function automatic trinj_pkg::slot_t mk_slot(bit conf, bit tip, int id);
    return {16'($urandom), 16'($urandom), 3'($urandom), 3'(id), tip, conf};
  endfunction

  function automatic trinj_pkg::slot_t rand_slot();
    return trinj_pkg::slot_t'({$urandom, $urandom});
  endfunction

  function automatic trinj_pkg::report_t build(trinj_pkg::byte_t rid,
                                               trinj_pkg::slot_t s0, trinj_pkg::slot_t s1,
                                               trinj_pkg::slot_t s2, trinj_pkg::slot_t s3,
                                               trinj_pkg::slot_t s4, trinj_pkg::byte_t cnt);
    trinj_pkg::report_t r;
    r.rpt_id = rid;
    r.contact_0 = s0;
    r.contact_1 = s1;
    r.contact_2 = s2;
    r.contact_3 = s3;
    r.contact_4 = s4;
    r.scan_stamp = 16'($urandom);
    r.num_contacts = cnt;
    r.button = trinj_pkg::byte_t'($urandom);
    r.reserved_byte = trinj_pkg::byte_t'($urandom);
    return r;
  endfunction

  function automatic trinj_pkg::report_t random_report();
    trinj_pkg::slot_t s [trinj_pkg::SlotCount];
    trinj_pkg::slot_t base;
    int               kind;
    int               n;
    int               ids [trinj_pkg::SlotCount];
    int               j;
    int               t;
    trinj_pkg::byte_t rid;
    kind = $urandom_range(99);
    rid = ($urandom_range(99) < 80) ? sb.match : trinj_pkg::byte_t'($urandom);
    foreach (s[i]) s[i] = ($urandom_range(99) < 70) ? trinj_pkg::slot_t'(0) : rand_slot();
    n = 0;
    if (kind < 20) begin
      foreach (s[i]) s[i] = rand_slot();
      n = ($urandom_range(1) == 1) ? $urandom_range(0, 7) : $urandom_range(0, 255);
    end else if (kind < 60) begin
      for (int i = 0; i < trinj_pkg::SlotCount; i++) begin
        base = sb.stored[i];
        if (base[trinj_pkg::ConfBit] && base[trinj_pkg::TipBit]
            && base[trinj_pkg::IdMsb:trinj_pkg::IdLsb] < trinj_pkg::SlotCount
            && $urandom_range(99) < 65) begin
          base[trinj_pkg::SlotWidth-1:8] = $urandom;
          if ($urandom_range(99) < 10) base[trinj_pkg::ConfBit] = 1'b0;
          if ($urandom_range(99) < 15) base[trinj_pkg::TipBit] = 1'b0;
          s[n] = base;
          n++;
        end
      end
    end else begin
      n = $urandom_range(0, trinj_pkg::SlotCount);
      foreach (ids[i]) ids[i] = i;
      for (int i = trinj_pkg::SlotCount - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = ids[i];
        ids[i] = ids[j];
        ids[j] = t;
      end
      for (int i = 0; i < n; i++) begin
        s[i] = mk_slot($urandom_range(99) < 90, $urandom_range(99) < 75, ids[i]);
      end
      if ($urandom_range(99) < 10) n = $urandom_range(trinj_pkg::SlotCount, 255);
    end
    return build(rid, s[0], s[1], s[2], s[3], s[4], trinj_pkg::byte_t'(n));
  endfunction

  task automatic send_report(input trinj_pkg::report_t r);
    bit taken;
    while ($urandom_range(99) < send_idle) begin
      report_valid <= 1'b0;
      @(posedge clk);
    end
    report <= r;
    report_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !report_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic run_batch(input int count);
    for (int i = 0; i < count; i++) send_report(random_report());
    report_valid <= 1'b0;
  endtask

  task automatic write_match(input trinj_pkg::byte_t v);
    bit taken;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    sb.set_match(v);
  endtask

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    trinj_pkg::report_t ones;
    trinj_pkg::byte_t   v;
    trinj_pkg::slot_t   z;
    sb = new();
    z = '0;
    ones = '1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_report(build(8'd3, z, z, z, z, z, 8'd0));
    send_report(ones);
    send_report(build(8'd3, mk_slot(1'b1, 1'b1, 0), mk_slot(1'b1, 1'b1, 1),
                      mk_slot(1'b1, 1'b1, 2), mk_slot(1'b1, 1'b1, 3),
                      mk_slot(1'b1, 1'b1, 4), 8'd5));
    send_report(build(8'd3, mk_slot(1'b1, 1'b1, 0), mk_slot(1'b1, 1'b1, 1), z, z, z, 8'd2));
    send_report(build(8'd3, mk_slot(1'b1, 1'b1, 0), mk_slot(1'b1, 1'b1, 1), z, z, z, 8'd2));
    send_report(build(8'd7, rand_slot(), rand_slot(), rand_slot(), rand_slot(),
                      rand_slot(), 8'd0));
    send_report(build(8'd3, mk_slot(1'b1, 1'b1, 0), mk_slot(1'b1, 1'b1, 1),
                      mk_slot(1'b1, 1'b1, 2), mk_slot(1'b1, 1'b1, 3),
                      mk_slot(1'b1, 1'b1, 4), 8'd200));
    send_report(build(8'd3, mk_slot(1'b1, 1'b1, 0), z, z, z, z, 8'd6));
    send_report(build(8'd3, mk_slot(1'b1, 1'b1, 5), mk_slot(1'b1, 1'b1, 6),
                      mk_slot(1'b1, 1'b1, 7), z, z, 8'd3));
    send_report(build(8'd3, z, z, z, z, z, 8'd0));
    send_report(build(8'd3, mk_slot(1'b1, 1'b1, 1), z, mk_slot(1'b1, 1'b1, 1), z, z, 8'd2));
    send_report(build(8'd3, z, z, z, z, z, 8'd0));
    send_report(build(8'd3, mk_slot(1'b1, 1'b0, 0), mk_slot(1'b1, 1'b0, 1),
                      mk_slot(1'b1, 1'b0, 2), mk_slot(1'b1, 1'b0, 3),
                      mk_slot(1'b1, 1'b0, 4), 8'd1));
    send_report(build(8'd3, z, z, z, z, z, 8'd0));
    send_report(build(8'd3, mk_slot(1'b1, 1'b1, 0), mk_slot(1'b1, 1'b1, 1),
                      mk_slot(1'b1, 1'b1, 2), z, z, 8'd3));
    send_report(build(8'd3, mk_slot(1'b0, 1'b1, 0), z, z, z, z, 8'd1));
    ones.rpt_id = 8'd3;
    send_report(ones);
    send_report(build(8'd3, mk_slot(1'b1, 1'b1, 0), mk_slot(1'b1, 1'b1, 1), z, z, z,
                      8'd254));
    report_valid <= 1'b0;

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle = 34;
          recv_idle = 59;
        end
        1: begin
          send_idle = 59;
          recv_idle = 34;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (seg)
        0: v = 8'h00;
        1: v = 8'hFF;
        3: v = trinj_pkg::ReportMatchReset;
        5: v = 8'h01;
        default: v = trinj_pkg::byte_t'($urandom);
      endcase
      write_match(v);
      run_batch(90);
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.errors += sb.pending();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/trinj_pkg.sv
sv/trinj_repair.sv
sv/touch_release_injector_top.sv
verif/touch_release_injector_top_test.sv
